// ===== rtl/gnls_pkg.sv =====
package gnls_pkg;

    localparam int TEXT_W = 64;
    localparam int LEN_W  = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        PH_SKIP_OBJ,
        PH_OBJ,
        PH_NAME_START,
        PH_SKIP_NAME,
        PH_NAME
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_END,
        ST_EMIT_OBJ,
        ST_EMIT_NAME
    } t_state;

    // One stored name or object: packed text, kept length and truncation flag.
    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
        logic              cut;
    } t_entry;

    typedef struct packed {
        logic              kind;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  text_len;
        logic              truncated;
        logic              list_overflow;
        logic              last;
    } t_result;

endpackage

// ===== rtl/gnls_in_if.sv =====
interface gnls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ===== rtl/gnls_out_if.sv =====
interface gnls_out_if;
    import gnls_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grouped_name_list_sorter_top.sv =====
// Parses a byte stream of groups "object: name, name;" (byte 0 ends the text) and, at the end
// of each group that has an object and at least one name, emits the object followed by its
// names in ascending unsigned byte order, one result per transfer, with last set on the final
// name. A name that completes is insertion-sorted in a one-port-read, one-port-write list
// memory, moving one entry per cycle; no byte is accepted while it moves. A group end passes
// through an end state, then the object and each name leave one per cycle from the output
// register while the output is not stalled, the read of each name overlapping the transfer
// before it. Input is taken again as soon as the last result sits in the output register.
module grouped_name_list_sorter_top #(
    parameter int LIST_DEPTH = 8,
    parameter int NAME_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gnls_in_if.sink           i_in,
    gnls_out_if.source        o_out
);
    import gnls_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    function automatic t_entry append_byte(t_entry e, logic [7:0] ch);
        t_entry r;
        r = e;
        if (e.len < LEN_W'(NAME_BYTES)) begin
            r.text = e.text | ({ch, {(TEXT_W-8){1'b0}}} >> {e.len[2:0], 3'b000});
            r.len  = e.len + LEN_W'(1);
        end else begin
            r.cut = 1'b1;
        end
        return r;
    endfunction

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    t_entry          r_obj, n_obj;
    t_entry          r_name, n_name;
    logic [CW-1:0]   r_count, n_count;
    logic            r_dropped, n_dropped;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_end, n_end;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;
    t_entry          r_rd_data;
    t_entry          r_mem [LIST_DEPTH];

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    t_entry          mem_wd;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic            in_fire;
    logic            out_free;
    logic            list_full;
    logic            ins_done;
    logic            last_name;
    logic            emit_group;

    // Decoded action of the accepted byte.
    logic            dec_obj_app;
    logic            dec_name_app;
    logic            dec_insert;
    logic            dec_end;
    t_phase          dec_phase;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in.valid & i_in.ready;
    assign out_free    = ~r_out_valid | o_out.ready;
    assign list_full   = (r_count == CW'(LIST_DEPTH));
    assign ins_done    = (r_idx == '0) || !(r_name.text < r_rd_data.text);
    assign last_name   = ((CW'(r_idx) + CW'(1)) == r_count);
    assign emit_group  = (r_obj.len != '0) && (r_count != '0);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        logic is_sep;
        logic is_term;
        is_sep       = (i_in.ch == CH_SPACE) || (i_in.ch == CH_COMMA);
        is_term      = (i_in.ch == CH_NUL);
        dec_obj_app  = 1'b0;
        dec_name_app = 1'b0;
        dec_insert   = 1'b0;
        dec_end      = 1'b0;
        dec_phase    = r_phase;
        case (r_phase)
            PH_SKIP_OBJ: begin
                if (is_term) begin
                    dec_end = 1'b1;
                end else if (i_in.ch == CH_COLON) begin
                    dec_phase = PH_NAME_START;
                end else if (!is_sep) begin
                    dec_obj_app = 1'b1;
                    dec_phase   = PH_OBJ;
                end
            end
            PH_OBJ: begin
                if (is_term) begin
                    dec_end = 1'b1;
                end else if (i_in.ch == CH_COLON) begin
                    dec_phase = PH_NAME_START;
                end else begin
                    dec_obj_app = 1'b1;
                end
            end
            PH_NAME_START: begin
                if (is_term || i_in.ch == CH_SEMI) begin
                    dec_end = 1'b1;
                end else if (is_sep) begin
                    dec_phase = PH_SKIP_NAME;
                end else begin
                    dec_name_app = 1'b1;
                    dec_phase    = PH_NAME;
                end
            end
            PH_SKIP_NAME: begin
                if (is_term || i_in.ch == CH_SEMI) begin
                    dec_insert = 1'b1;
                    dec_end    = 1'b1;
                end else if (!is_sep) begin
                    dec_name_app = 1'b1;
                    dec_phase    = PH_NAME;
                end
            end
            PH_NAME: begin
                if (is_term || i_in.ch == CH_SEMI) begin
                    dec_insert = 1'b1;
                    dec_end    = 1'b1;
                end else if (i_in.ch == CH_COMMA) begin
                    dec_insert = 1'b1;
                    dec_phase  = PH_SKIP_NAME;
                end else begin
                    dec_name_app = 1'b1;
                end
            end
            default: begin
                dec_phase = PH_SKIP_OBJ;
            end
        endcase
        if (dec_end) begin
            dec_phase = PH_SKIP_OBJ;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (dec_insert && !list_full) begin
                        n_state = ST_INSERT;
                    end else if (dec_end) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_INSERT: begin
                if (ins_done) begin
                    n_state = r_end ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                n_state = emit_group ? ST_EMIT_OBJ : ST_IDLE;
            end
            ST_EMIT_OBJ: begin
                if (out_free) begin
                    n_state = ST_EMIT_NAME;
                end
            end
            ST_EMIT_NAME: begin
                if (out_free && last_name) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic clear_group;
        clear_group = 1'b0;
        n_phase     = r_phase;
        n_obj       = r_obj;
        n_name      = r_name;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_idx       = r_idx;
        n_end       = r_end;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_out.ready;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = r_name;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_phase = dec_phase;
                    if (dec_obj_app) begin
                        n_obj = append_byte(r_obj, i_in.ch);
                    end
                    if (dec_name_app) begin
                        n_name = append_byte(r_name, i_in.ch);
                    end
                    if (dec_insert) begin
                        if (!list_full) begin
                            // The walk starts at the first free slot, comparing downwards.
                            n_idx = AW'(r_count);
                            n_end = dec_end;
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_count - CW'(1));
                            end
                        end else begin
                            n_dropped = 1'b1;
                            n_name    = '0;
                        end
                    end
                end
            end
            ST_INSERT: begin
                mem_we = 1'b1;
                if (ins_done) begin
                    mem_wd  = r_name;
                    n_count = r_count + CW'(1);
                    n_name  = '0;
                end else begin
                    // Shift the larger entry up one slot and fetch the next one down.
                    mem_wd = r_rd_data;
                    n_idx  = r_idx - AW'(1);
                    if (r_idx > AW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(2);
                    end
                end
            end
            ST_END: begin
                if (!emit_group) begin
                    clear_group = 1'b1;
                end
            end
            ST_EMIT_OBJ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: 1'b0, text: r_obj.text, text_len: r_obj.len,
                                    truncated: r_obj.cut, list_overflow: r_dropped,
                                    last: 1'b0};
                    n_idx       = '0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                end
            end
            ST_EMIT_NAME: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: 1'b1, text: r_rd_data.text,
                                    text_len: r_rd_data.len, truncated: r_rd_data.cut,
                                    list_overflow: r_dropped, last: last_name};
                    if (last_name) begin
                        clear_group = 1'b1;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        rd_en   = 1'b1;
                        rd_addr = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                clear_group = 1'b1;
            end
        endcase

        if (clear_group) begin
            n_phase   = PH_SKIP_OBJ;
            n_obj     = '0;
            n_name    = '0;
            n_count   = '0;
            n_dropped = 1'b0;
            n_end     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SKIP_OBJ;
            r_obj       <= '0;
            r_name      <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx       <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_obj       <= n_obj;
            r_name      <= n_name;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/gnls_checker.sv =====
module gnls_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input gnls_pkg::t_result i_out_data
);
    import gnls_pkg::*;

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or vanished while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    // While a group is being emitted no text byte may be taken.
    a_no_input_mid_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last |-> !i_in_ready)
        else $error("input taken before the group's last result");

    // An object is always followed at once by its first name.
    a_object_then_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.kind |=> i_out_valid && i_out_data.kind)
        else $error("object transfer not followed by a name");

endmodule

bind grouped_name_list_sorter_top gnls_checker u_gnls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gnls_pkg::*;

    localparam int LIST_DEPTH   = 8;
    localparam int NAME_BYTES   = 8;
    localparam int TARGET_BYTES = 480;
    localparam int CALM_BYTES   = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;

    localparam logic KIND_OBJECT = 1'b0;
    localparam logic KIND_NAME   = 1'b1;

    // Tracks the parse of the byte stream and holds the results each group end should emit.
    class sorted_group_board #(int DEPTH = 8, int KEEP = 8);
        t_phase  phase;
        t_entry  object_entry;
        t_entry  name_entry;
        t_entry  held_names[DEPTH];
        int      held_count;
        logic    names_lost;
        t_result due_results[$];
        int      fails;

        function new();
            fails = 0;
            foreach (held_names[i]) held_names[i] = '0;
            clear_group();
        endfunction

        function void clear_group();
            phase        = PH_SKIP_OBJ;
            object_entry = '0;
            name_entry   = '0;
            held_count   = 0;
            names_lost   = 1'b0;
        endfunction

        function t_entry with_byte(t_entry e, logic [7:0] c);
            if (int'(e.len) < KEEP) begin
                e.text[(TEXT_W - 1) - 8 * int'(e.len) -: 8] = c;
                e.len = e.len + LEN_W'(1);
            end else begin
                e.cut = 1'b1;
            end
            return e;
        endfunction

        // Equal names settle after those already held, so the walk stops on equality.
        function void insert_name();
            int i;
            if (held_count < DEPTH) begin
                i = held_count;
                while (i > 0 && name_entry.text < held_names[i - 1].text) begin
                    held_names[i] = held_names[i - 1];
                    i--;
                end
                held_names[i] = name_entry;
                held_count++;
            end else begin
                names_lost = 1'b1;
            end
            name_entry = '0;
        endfunction

        function void push_result(logic kind, t_entry e, logic is_last);
            t_result r;
            r.kind          = kind;
            r.text          = e.text;
            r.text_len      = e.len;
            r.truncated     = e.cut;
            r.list_overflow = names_lost;
            r.last          = is_last;
            due_results.push_back(r);
        endfunction

        function void close_group();
            if (object_entry.len != 0 && held_count > 0) begin
                push_result(KIND_OBJECT, object_entry, 1'b0);
                for (int i = 0; i < held_count; i++)
                    push_result(KIND_NAME, held_names[i], i == held_count - 1);
            end
            clear_group();
        endfunction

        function void note_byte(logic [7:0] c);
            logic sep;
            logic stop;
            sep  = (c == CH_SPACE) || (c == CH_COMMA);
            stop = (c == CH_NUL) || (c == CH_SEMI);
            case (phase)
                PH_SKIP_OBJ, PH_OBJ: begin
                    if (c == CH_NUL) begin
                        close_group();
                    end else if (c == CH_COLON) begin
                        phase = PH_NAME_START;
                    end else if (!(sep && phase == PH_SKIP_OBJ)) begin
                        object_entry = with_byte(object_entry, c);
                        phase = PH_OBJ;
                    end
                end
                PH_NAME_START: begin
                    if (stop) begin
                        close_group();
                    end else if (sep) begin
                        phase = PH_SKIP_NAME;
                    end else begin
                        name_entry = with_byte(name_entry, c);
                        phase = PH_NAME;
                    end
                end
                PH_SKIP_NAME: begin
                    if (stop) begin
                        insert_name();
                        close_group();
                    end else if (!sep) begin
                        name_entry = with_byte(name_entry, c);
                        phase = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (stop) begin
                        insert_name();
                        close_group();
                    end else if (c == CH_COMMA) begin
                        insert_name();
                        phase = PH_SKIP_NAME;
                    end else begin
                        name_entry = with_byte(name_entry, c);
                    end
                end
                default: phase = PH_SKIP_OBJ;
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                fails++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                fails++;
            end else begin
                want = due_results.pop_front();
                compare_field("kind", 64'(want.kind), 64'(got.kind));
                compare_field("text", want.text, got.text);
                compare_field("text_len", 64'(want.text_len), 64'(got.text_len));
                compare_field("truncated", 64'(want.truncated), 64'(got.truncated));
                compare_field("list_overflow", 64'(want.list_overflow),
                              64'(got.list_overflow));
                compare_field("last", 64'(want.last), 64'(got.last));
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic idle_on = 1'b0;
    int   bytes_sent = 0;
    int   cycles = 0;

    gnls_in_if  in_if ();
    gnls_out_if out_if ();

    sorted_group_board #(LIST_DEPTH, NAME_BYTES) board;

    grouped_name_list_sorter_top #(
        .LIST_DEPTH(LIST_DEPTH),
        .NAME_BYTES(NAME_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("grouped_name_list_sorter_top test failed");
            $finish;
        end
    end

    // Results are checked before the byte of the same edge is noted; a result can never
    // stem from a byte accepted at that very edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_if.valid && out_if.ready) board.check_result(out_if.data);
            if (in_if.valid && in_if.ready) board.note_byte(in_if.ch);
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch    <= c;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] sep_byte();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COMMA;
    endfunction

    function automatic int text_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(9, 12);
        return $urandom_range(1, 4);
    endfunction

    // A small alphabet makes equal and prefix-sharing names common.
    function automatic logic [7:0] object_byte();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0) return 8'h61 + 8'($urandom_range(0, 2));
        do c = 8'($urandom_range(1, 255)); while (c == CH_COLON);
        return c;
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0) return 8'h61 + 8'($urandom_range(0, 2));
        do c = 8'($urandom_range(1, 255)); while (c == CH_SEMI || c == CH_COMMA);
        return c;
    endfunction

    task automatic send_group();
        int style;
        int name_total;
        int obj_len;
        style = $urandom_range(0, 11);
        if (style == 0) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            obj_len = ($urandom_range(0, 11) == 0) ? 0 : text_length();
            repeat ($urandom_range(0, 2)) send_byte(sep_byte());
            repeat (obj_len) send_byte(object_byte());
            if (style == 1) begin
                // Broken group: the text ends inside the object.
                send_byte(CH_NUL);
            end else begin
                send_byte(CH_COLON);
                name_total = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12)
                                                         : $urandom_range(0, 5);
                for (int n = 0; n < name_total; n++) begin
                    repeat ($urandom_range(0, 2)) send_byte(sep_byte());
                    repeat (text_length()) send_byte(name_byte());
                    if (n != name_total - 1) send_byte(CH_COMMA);
                end
                if ($urandom_range(0, 4) == 0) send_byte(CH_NUL);
                else send_byte(CH_SEMI);
            end
        end
    endtask

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.ch     = CH_NUL;
        out_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Object with leading separators, a top byte, an inner ';' and a trailing space.
        send_byte(CH_COMMA);
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        send_text("o; :b,");
        send_byte(8'h01);
        send_text("A;");
        // Empty object, empty name, group without names, end of text inside an object.
        send_text(":a;x:,;y:;z");
        send_byte(CH_NUL);
        // Over-long object and name.
        send_text("ABCDEFGHI:123456789;");

        while (bytes_sent < TARGET_BYTES) begin
            idle_on = (bytes_sent < CALM_BYTES) && ($urandom_range(0, 3) != 0);
            send_group();
        end
        idle_on = 1'b0;
        send_byte(CH_NUL);
        in_if.valid <= 1'b0;
        @(posedge i_clk);

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fails == 0)
            $display("grouped_name_list_sorter_top test passed");
        else
            $display("grouped_name_list_sorter_top test failed");
        $finish;
    end
endmodule
